// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStretchLimit = 2'd1;

  // configuration reset values
  localparam logic [7:0] HalfPeriodRst   = 8'd5;
  localparam logic [7:0] StretchLimitRst = 8'd25;

  // command codes
  localparam logic [2:0] ModeNone  = 3'd0;
  localparam logic [2:0] ModeStart = 3'd1;
  localparam logic [2:0] ModeStop  = 3'd2;
  localparam logic [2:0] ModeWrite = 3'd3;
  localparam logic [2:0] ModeRead  = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       scl_in;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_data;
    logic       stretch_timeout;
  } res_t;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] stretch_limit;
  } cfg_t;

endpackage

// File: sv/i2cm_intf.sv
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// valid/ready channels for commands, results and configuration writes
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_byte;
  logic       scl_in;
  logic       sda_in;

  modport source (output valid, output mode, output data_byte, output scl_in,
                  output sda_in, input ready);
  modport sink (input valid, input mode, input data_byte, input scl_in,
                input sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic       ack_received;
  logic [7:0] read_data;
  logic       stretch_timeout;

  modport source (output valid, output scl_drive_low, output sda_drive_low,
                  output busy_res, output done_res, output ack_received,
                  output read_data, output stretch_timeout, input ready);
  modport sink (input valid, input scl_drive_low, input sda_drive_low,
                input busy_res, input done_res, input ack_received,
                input read_data, input stretch_timeout, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// configuration registers written through the config channel
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] wr_data_i,
  output i2cm_pkg::cfg_t               cfg_o
);
  import i2cm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        CfgHalfPeriod:   cfg_d.half_period_ticks = wr_data_i;
        CfgStretchLimit: cfg_d.stretch_limit     = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HalfPeriodRst;
      cfg_q.stretch_limit     <= StretchLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// phase sequencer: one tick of bus timing per step
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2cm_pkg::cmd_t cmd_i,
  input  i2cm_pkg::cfg_t cfg_i,
  output i2cm_pkg::res_t res_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PhIdle   = 4'd0,
    PhStaA   = 4'd1,
    PhStaB   = 4'd2,
    PhStoA   = 4'd3,
    PhStoB   = 4'd4,
    PhStoC   = 4'd5,
    PhWrDat  = 4'd6,
    PhWrHi   = 4'd7,
    PhWrLo   = 4'd8,
    PhAckRel = 4'd9,
    PhAckHi  = 4'd10,
    PhAckLo  = 4'd11,
    PhRdHi   = 4'd12,
    PhRdLo   = 4'd13,
    PhNakHi  = 4'd14,
    PhNakLo  = 4'd15
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_idx;
    logic [7:0] shift;
    logic [7:0] delay;
    logic [7:0] stretch;
    logic       scl_drv;
    logic       sda_drv;
    logic       timeout;
    logic       ack_hold;
    logic [7:0] read_hold;
  } seq_state_t;

  seq_state_t st_q, st_d;
  logic       done;
  logic       counting;
  logic       wait_ph;

  // enter a phase: clear the counters and set the line drives
  function automatic seq_state_t enter_phase(seq_state_t s, phase_e p);
    seq_state_t r;
    r = s;
    r.phase   = p;
    r.delay   = '0;
    r.stretch = '0;
    case (p)
      PhStaA:   r.sda_drv = 1'b1;
      PhStaB:   r.scl_drv = 1'b1;
      PhStoA:   r.sda_drv = 1'b1;
      PhStoB:   r.scl_drv = 1'b0;
      PhStoC:   r.sda_drv = 1'b0;
      PhWrDat:  r.sda_drv = ~s.shift[7];
      PhWrHi:   r.scl_drv = 1'b0;
      PhWrLo:   r.scl_drv = 1'b1;
      PhAckRel: r.sda_drv = 1'b0;
      PhAckHi:  r.scl_drv = 1'b0;
      PhAckLo:  r.scl_drv = 1'b1;
      PhRdHi: begin
        r.sda_drv = 1'b0;
        r.scl_drv = 1'b0;
      end
      PhRdLo:   r.scl_drv = 1'b1;
      PhNakHi: begin
        r.sda_drv = 1'b0;
        r.scl_drv = 1'b0;
      end
      PhNakLo:  r.scl_drv = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  assign wait_ph = (st_q.phase == PhStoB) || (st_q.phase == PhAckHi) ||
                   (st_q.phase == PhRdHi) || (st_q.phase == PhNakHi);

  always_comb begin
    st_d     = st_q;
    done     = 1'b0;
    counting = 1'b0;
    if (st_q.phase == PhIdle) begin
      case (cmd_i.mode)
        ModeStart: begin
          st_d.timeout = 1'b0;
          st_d.bit_idx = '0;
          st_d = enter_phase(st_d, PhStaA);
        end
        ModeStop: begin
          st_d.timeout = 1'b0;
          st_d.bit_idx = '0;
          st_d = enter_phase(st_d, PhStoA);
        end
        ModeWrite: begin
          st_d.timeout = 1'b0;
          st_d.bit_idx = '0;
          st_d.shift   = cmd_i.data_byte;
          st_d = enter_phase(st_d, PhWrDat);
        end
        ModeRead: begin
          st_d.timeout = 1'b0;
          st_d.bit_idx = '0;
          st_d.shift   = '0;
          st_d = enter_phase(st_d, PhRdHi);
        end
        default: ;
      endcase
    end else begin
      counting = 1'b1;
      // clock stretch: hold off the delay until scl reads high or the stretch limit is reached
      if (wait_ph && (st_q.delay == '0) && !cmd_i.scl_in) begin
        if (st_q.stretch >= cfg_i.stretch_limit) begin
          st_d.timeout = 1'b1;
        end else begin
          st_d.stretch = st_q.stretch + 8'd1;
          counting     = 1'b0;
        end
      end
      if (counting) begin
        if ((st_q.phase == PhRdHi) && (st_q.delay == '0)) begin
          st_d.shift = {st_q.shift[6:0], cmd_i.sda_in};
        end
        st_d.delay = st_q.delay + 8'd1;
        if (st_d.delay >= cfg_i.half_period_ticks) begin
          case (st_q.phase)
            PhStaA:   st_d = enter_phase(st_d, PhStaB);
            PhStoA:   st_d = enter_phase(st_d, PhStoB);
            PhStoB:   st_d = enter_phase(st_d, PhStoC);
            PhWrDat:  st_d = enter_phase(st_d, PhWrHi);
            PhWrHi:   st_d = enter_phase(st_d, PhWrLo);
            PhWrLo: begin
              st_d.shift   = {st_q.shift[6:0], 1'b0};
              st_d.bit_idx = st_q.bit_idx + 4'd1;
              st_d = enter_phase(st_d, st_d.bit_idx[3] ? PhAckRel : PhWrDat);
            end
            PhAckRel: st_d = enter_phase(st_d, PhAckHi);
            PhAckHi: begin
              st_d.ack_hold = ~cmd_i.sda_in;
              st_d = enter_phase(st_d, PhAckLo);
            end
            PhRdHi:   st_d = enter_phase(st_d, PhRdLo);
            PhRdLo: begin
              st_d.bit_idx = st_q.bit_idx + 4'd1;
              st_d = enter_phase(st_d, st_d.bit_idx[3] ? PhNakHi : PhRdHi);
            end
            PhNakHi:  st_d = enter_phase(st_d, PhNakLo);
            default: begin
              // last phase of a command
              if (st_q.phase == PhNakLo) begin
                st_d.read_hold = st_d.shift;
              end
              st_d.phase   = PhIdle;
              st_d.delay   = '0;
              st_d.stretch = '0;
              done         = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PhIdle, default: '0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign res_o.scl_drive_low   = st_d.scl_drv;
  assign res_o.sda_drive_low   = st_d.sda_drv;
  assign res_o.busy_res        = (st_d.phase != PhIdle);
  assign res_o.done_res        = done;
  assign res_o.ack_received    = st_d.ack_hold;
  assign res_o.read_data       = st_d.read_hold;
  assign res_o.stretch_timeout = st_d.timeout;

endmodule

// File: sv/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// open-drain i2c master driven one timing tick per command transaction
// ----------------------------------------------------------------------------
//  channel  dir   handshake      payload
//  cmd_i    in    valid/ready    mode, data_byte, scl_in, sda_in
//  res_o    out   valid/ready    scl/sda drives, busy, done, ack, read_data, timeout
//  cfg_i    in    valid/ready    index, data (0 half period, 1 stretch limit)
//
//  every command transaction is one tick and yields exactly one result
//  transaction; the sequencer state advances once per tick, so a tick is
//  taken every cycle while res_o is not stalled; a result passes through
//  the input register and then the sequencer step into the result register.
//  reset puts the sequencer in idle with both lines released and loads
//  the configuration defaults (5 ticks per half bit, 25 ticks stretch limit).
//  a stalled result holds the tick in the input register; ticks resume with
//  no bubble as soon as res_o.ready returns.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  i2cm_cmd_if.sink   cmd_i,
  i2cm_res_if.source res_o,
  i2cm_cfg_if.sink   cfg_i
);
  import i2cm_pkg::*;

  // input register
  logic in_valid_q;
  cmd_t cmd_q;
  // result register
  logic out_valid_q;
  res_t res_q;

  cfg_t cfg;
  res_t seq_res;
  logic advance;
  logic cmd_acc;

  // the tick moves into the sequencer when the result slot is free or draining
  assign advance = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;
  assign cmd_acc = cmd_i.valid && cmd_i.ready;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  i2cm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (cmd_q),
    .cfg_i  (cfg),
    .res_o  (seq_res)
  );

  // input register holds the tick until the sequencer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      cmd_q.mode      <= cmd_i.mode;
      cmd_q.data_byte <= cmd_i.data_byte;
      cmd_q.scl_in    <= cmd_i.scl_in;
      cmd_q.sda_in    <= cmd_i.sda_in;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= seq_res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.scl_drive_low   = res_q.scl_drive_low;
  assign res_o.sda_drive_low   = res_q.sda_drive_low;
  assign res_o.busy_res        = res_q.busy_res;
  assign res_o.done_res        = res_q.done_res;
  assign res_o.ack_received    = res_q.ack_received;
  assign res_o.read_data       = res_q.read_data;
  assign res_o.stretch_timeout = res_q.stretch_timeout;

  // a tick handed to the sequencer shows up as a result next cycle
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_o.valid)
    else $error("tick stepped but no result presented");

  // an empty input register never blocks a command
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> cmd_i.ready)
    else $error("input register empty but command not ready");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !advance) |=> !res_o.valid)
    else $error("result repeated after transaction");

  // a finished command reports idle in the same result
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && seq_res.done_res |=> !res_o.busy_res)
    else $error("done flagged while still busy");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the i2c master byte engine one tick at a time: a directed table of
// commands and line samples, then random bus sequences under several timing
// settings, each result held to a typed row or the in-bench sequencer model
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  // reserved command codes, the engine must drop them
  localparam logic [2:0] ModeBad5 = 3'd5;
  localparam logic [2:0] ModeBad6 = 3'd6;
  localparam logic [2:0] ModeBad7 = 3'd7;

  // bus sequencer phases, one per drive step of a command
  typedef enum logic [3:0] {
    PhIdle, PhStartSda, PhStartScl, PhStopSda, PhStopScl, PhStopRel,
    PhWrData, PhWrHigh, PhWrLow, PhAckRel, PhAckHigh, PhAckLow,
    PhRdHigh, PhRdLow, PhNakHigh, PhNakLow
  } seq_ph_e;

  // one directed tick, optionally followed by filler ticks until idle
  typedef struct packed {
    cmd_t       c;
    logic       typed;
    res_t       want;
    logic       to_idle;
    logic [2:0] fill_mode;
    logic       fill_scl;
    logic       fill_sda;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  i2cm_cmd_if cmd_ch ();
  i2cm_res_if res_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_master_byte_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // sequencer model state
  // --------------------------------------------------------------------------
  seq_ph_e    seq_ph;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  logic [7:0] dly_cnt;
  logic [7:0] wait_cnt;
  logic       scl_low;
  logic       sda_low;
  logic       to_flag;
  logic       ack_seen;
  logic [7:0] rd_byte;
  cfg_t       cfg_now;

  res_t        drive_status_q[$];   // predicted results, oldest first
  dir_row_t    dir_rows[$];
  int unsigned err_cnt = 0;
  bit          no_idle = 1'b0;      // both sides run without gaps
  bit          bus_open = 1'b0;     // a start was issued with no stop since
  int unsigned scl_hold_left = 0;   // remaining ticks of a held-low scl burst

  // entering a phase clears the counters and sets the line drives
  function automatic void enter_ph(seq_ph_e p);
    seq_ph   = p;
    dly_cnt  = '0;
    wait_cnt = '0;
    case (p)
      PhStartSda, PhStopSda: sda_low = 1'b1;
      PhStartScl, PhWrLow, PhAckLow, PhRdLow, PhNakLow: scl_low = 1'b1;
      PhStopScl, PhWrHigh, PhAckHigh: scl_low = 1'b0;
      PhStopRel, PhAckRel: sda_low = 1'b0;
      PhWrData: sda_low = ~shreg[7];
      PhRdHigh, PhNakHigh: begin
        sda_low = 1'b0;
        scl_low = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // move to the next phase, returns 1 when the command is complete
  function automatic bit leave_ph(logic sda);
    bit finished;
    finished = 1'b0;
    case (seq_ph)
      PhStartSda: enter_ph(PhStartScl);
      PhStopSda:  enter_ph(PhStopScl);
      PhStopScl:  enter_ph(PhStopRel);
      PhWrData:   enter_ph(PhWrHigh);
      PhWrHigh:   enter_ph(PhWrLow);
      PhWrLow: begin
        shreg   = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) enter_ph(PhAckRel);
        else enter_ph(PhWrData);
      end
      PhAckRel: enter_ph(PhAckHigh);
      PhAckHigh: begin
        // slave ack is sda pulled low at the end of the high phase
        ack_seen = ~sda;
        enter_ph(PhAckLow);
      end
      PhRdHigh: enter_ph(PhRdLow);
      PhRdLow: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) enter_ph(PhNakHigh);
        else enter_ph(PhRdHigh);
      end
      PhNakHigh: enter_ph(PhNakLow);
      PhNakLow: begin
        rd_byte  = shreg;
        finished = 1'b1;
      end
      default: finished = 1'b1;
    endcase
    if (finished) begin
      seq_ph   = PhIdle;
      dly_cnt  = '0;
      wait_cnt = '0;
    end
    return finished;
  endfunction

  // one tick of the engine: returns the result that tick produces
  function automatic res_t i2c_seq_step(cmd_t c);
    res_t r;
    bit   done;
    bit   counting;
    done = 1'b0;
    if (seq_ph == PhIdle) begin
      if (c.mode >= ModeStart && c.mode <= ModeRead) begin
        to_flag = 1'b0;
        bit_cnt = '0;
        case (c.mode)
          ModeStart: enter_ph(PhStartSda);
          ModeStop:  enter_ph(PhStopSda);
          ModeWrite: begin
            shreg = c.data_byte;
            enter_ph(PhWrData);
          end
          default: begin
            shreg = '0;
            enter_ph(PhRdHigh);
          end
        endcase
      end
    end else begin
      counting = 1'b1;
      // clock stretching: stop, ack, read and nak phases that release scl wait for it to read high
      if ((seq_ph == PhStopScl || seq_ph == PhAckHigh || seq_ph == PhRdHigh ||
           seq_ph == PhNakHigh) && dly_cnt == 8'd0 && !c.scl_in) begin
        if (wait_cnt >= cfg_now.stretch_limit) begin
          to_flag = 1'b1;
        end else begin
          wait_cnt = wait_cnt + 8'd1;
          counting = 1'b0;
        end
      end
      if (counting) begin
        if (seq_ph == PhRdHigh && dly_cnt == 8'd0) shreg = {shreg[6:0], c.sda_in};
        dly_cnt = dly_cnt + 8'd1;
        // a zero half period acts as one tick
        if (dly_cnt >= cfg_now.half_period_ticks) done = leave_ph(c.sda_in);
      end
    end
    r.scl_drive_low   = scl_low;
    r.sda_drive_low   = sda_low;
    r.busy_res        = (seq_ph != PhIdle);
    r.done_res        = done;
    r.ack_received    = ack_seen;
    r.read_data       = rd_byte;
    r.stretch_timeout = to_flag;
    return r;
  endfunction

  // typed expectation for rows where only drives and busy can be nonzero
  function automatic res_t line_status(logic scl, logic sda, logic busy);
    res_t r;
    r = '0;
    r.scl_drive_low = scl;
    r.sda_drive_low = sda;
    r.busy_res      = busy;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] mode, logic [7:0] data, logic scl,
                                  logic sda, logic typed, res_t want,
                                  logic to_idle, logic [2:0] fill_mode,
                                  logic fill_scl, logic fill_sda);
    dir_row_t row;
    row.c.mode      = mode;
    row.c.data_byte = data;
    row.c.scl_in    = scl;
    row.c.sda_in    = sda;
    row.typed       = typed;
    row.want        = want;
    row.to_idle     = to_idle;
    row.fill_mode   = fill_mode;
    row.fill_scl    = fill_scl;
    row.fill_sda    = fill_sda;
    dir_rows.push_back(row);
  endfunction

  // random tick: mostly well-formed start / byte / stop sequences, with scl
  // held low in bursts to provoke stretching, plus some command noise
  function automatic cmd_t next_random_tick();
    cmd_t        c;
    int unsigned roll;
    c.data_byte = 8'($urandom_range(255));
    c.sda_in    = 1'($urandom_range(1));
    if (scl_hold_left > 0) begin
      c.scl_in      = 1'b0;
      scl_hold_left = scl_hold_left - 1;
    end else begin
      c.scl_in = ($urandom_range(99) >= 3);
      if ($urandom_range(99) < 2) scl_hold_left = $urandom_range(40, 1);
    end
    roll = $urandom_range(99);
    if (roll < 10) begin
      c.mode = 3'($urandom_range(7));
    end else if (seq_ph != PhIdle || roll < 20) begin
      c.mode = ModeNone;
    end else if (!bus_open) begin
      c.mode = ModeStart;
    end else begin
      roll = $urandom_range(99);
      if (roll < 45) c.mode = ModeWrite;
      else if (roll < 80) c.mode = ModeRead;
      else c.mode = ModeStop;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------
  // drive one tick, wait for its transaction, then queue the prediction
  task automatic send_tick(input cmd_t c, input logic typed, input res_t want);
    res_t pred;
    if (!no_idle) begin
      while ($urandom_range(99) < 15) begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.mode      <= c.mode;
    cmd_ch.data_byte <= c.data_byte;
    cmd_ch.scl_in    <= c.scl_in;
    cmd_ch.sda_in    <= c.sda_in;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    if (seq_ph == PhIdle && c.mode == ModeStart) bus_open = 1'b1;
    if (seq_ph == PhIdle && c.mode == ModeStop) bus_open = 1'b0;
    pred = i2c_seq_step(c);
    drive_status_q.push_back(typed ? want : pred);
  endtask

  // stop sending and wait until every queued result has come back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (drive_status_q.size() != 0) @(posedge clk_i);
  endtask

  // both registers, back to back, valid held high across the two writes
  task automatic write_cfg(input cfg_t c);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CfgHalfPeriod;
    cfg_ch.data  <= c.half_period_ticks;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.index <= CfgStretchLimit;
    cfg_ch.data  <= c.stretch_limit;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    cfg_now = c;
  endtask

  // --------------------------------------------------------------------------
  // result side: random backpressure, except in the gap-free stretch
  // --------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.scl_drive_low   = res_ch.scl_drive_low;
      got.sda_drive_low   = res_ch.sda_drive_low;
      got.busy_res        = res_ch.busy_res;
      got.done_res        = res_ch.done_res;
      got.ack_received    = res_ch.ack_received;
      got.read_data       = res_ch.read_data;
      got.stretch_timeout = res_ch.stretch_timeout;
      if (drive_status_q.size() == 0) begin
        if (err_cnt < 10) $display("%0t: result transaction with none pending", $time);
        err_cnt++;
      end else begin
        want = drive_status_q.pop_front();
        if (got.scl_drive_low !== want.scl_drive_low ||
            got.sda_drive_low !== want.sda_drive_low ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.ack_received !== want.ack_received ||
            got.read_data !== want.read_data ||
            got.stretch_timeout !== want.stretch_timeout) begin
          if (err_cnt < 10) begin
            $display("%0t: exp scl=%b sda=%b busy=%b done=%b ack=%b rd=%h to=%b",
                     $time, want.scl_drive_low, want.sda_drive_low, want.busy_res,
                     want.done_res, want.ack_received, want.read_data,
                     want.stretch_timeout);
            $display("%0t: got scl=%b sda=%b busy=%b done=%b ack=%b rd=%h to=%b",
                     $time, got.scl_drive_low, got.sda_drive_low, got.busy_res,
                     got.done_res, got.ack_received, got.read_data,
                     got.stretch_timeout);
          end
          err_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t        phase_cfg[5];
    int unsigned phase_len[5];
    bit          phase_calm[5];
    cmd_t        f;

    cmd_ch.valid     <= 1'b0;
    cmd_ch.mode      <= ModeNone;
    cmd_ch.data_byte <= '0;
    cmd_ch.scl_in    <= 1'b1;
    cmd_ch.sda_in    <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CfgHalfPeriod;
    cfg_ch.data      <= '0;

    // model reset state
    cfg_now.half_period_ticks = HalfPeriodRst;
    cfg_now.stretch_limit     = StretchLimitRst;
    seq_ph   = PhIdle;
    bit_cnt  = '0;
    shreg    = '0;
    dly_cnt  = '0;
    wait_cnt = '0;
    scl_low  = 1'b0;
    sda_low  = 1'b0;
    to_flag  = 1'b0;
    ack_seen = 1'b0;
    rd_byte  = '0;

    // directed table, reset configuration
    // after reset: both lines released, nothing held
    add_row(ModeNone, 8'h00, 1'b1, 1'b1, 1'b1, line_status(1'b0, 1'b0, 1'b0),
            1'b0, ModeNone, 1'b1, 1'b1);
    // reserved codes are ignored from idle
    add_row(ModeBad5, 8'hff, 1'b0, 1'b0, 1'b1, line_status(1'b0, 1'b0, 1'b0),
            1'b0, ModeNone, 1'b1, 1'b1);
    add_row(ModeBad6, 8'h00, 1'b1, 1'b0, 1'b1, line_status(1'b0, 1'b0, 1'b0),
            1'b0, ModeNone, 1'b1, 1'b1);
    add_row(ModeBad7, 8'hff, 1'b0, 1'b1, 1'b1, line_status(1'b0, 1'b0, 1'b0),
            1'b0, ModeNone, 1'b1, 1'b1);
    // stop on an idle bus: first phase pulls sda low with scl released
    add_row(ModeStop, 8'h00, 1'b1, 1'b1, 1'b1, line_status(1'b0, 1'b1, 1'b1),
            1'b1, ModeNone, 1'b1, 1'b1);
    // start, with a write offered on every busy tick including the done tick
    add_row(ModeStart, 8'h00, 1'b1, 1'b1, 1'b1, line_status(1'b0, 1'b1, 1'b1),
            1'b1, ModeWrite, 1'b1, 1'b0);
    // all-ones byte: msb released with scl still low; slave acks
    add_row(ModeWrite, 8'hff, 1'b1, 1'b1, 1'b1, line_status(1'b1, 1'b0, 1'b1),
            1'b1, ModeRead, 1'b1, 1'b0);
    // all-zeros byte, no ack
    add_row(ModeWrite, 8'h00, 1'b1, 1'b0, 1'b0, '0, 1'b1, ModeStop, 1'b1, 1'b1);
    // read all ones, then all zeros
    add_row(ModeRead, 8'hff, 1'b1, 1'b1, 1'b0, '0, 1'b1, ModeNone, 1'b1, 1'b1);
    add_row(ModeRead, 8'h00, 1'b1, 1'b0, 1'b0, '0, 1'b1, ModeStart, 1'b1, 1'b0);
    // scl stuck low: the ack wait runs out its stretch limit
    add_row(ModeWrite, 8'ha5, 1'b0, 1'b0, 1'b0, '0, 1'b1, ModeNone, 1'b0, 1'b0);
    // stop, then a write while it is still busy
    add_row(ModeStop, 8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b0, ModeNone, 1'b1, 1'b1);
    add_row(ModeWrite, 8'h5a, 1'b0, 1'b0, 1'b0, '0, 1'b1, ModeNone, 1'b0, 1'b0);
    add_row(ModeStart, 8'h00, 1'b1, 1'b1, 1'b0, '0, 1'b1, ModeNone, 1'b1, 1'b1);
    add_row(ModeStop, 8'h00, 1'b1, 1'b1, 1'b0, '0, 1'b1, ModeNone, 1'b1, 1'b1);
    add_row(ModeNone, 8'h00, 1'b1, 1'b1, 1'b0, '0, 1'b0, ModeNone, 1'b1, 1'b1);

    // random phases: several timing settings, the extremes among them;
    // the slowest setting gets a single tick so it runs at most one command
    phase_cfg[0] = {8'd1, 8'd0};     phase_len[0] = 40;  phase_calm[0] = 1'b0;
    phase_cfg[1] = {8'd0, 8'd255};   phase_len[1] = 30;  phase_calm[1] = 1'b0;
    phase_cfg[2] = {8'd2, 8'd3};     phase_len[2] = 60;  phase_calm[2] = 1'b1;
    phase_cfg[3] = {8'd6, 8'd1};     phase_len[3] = 1;   phase_calm[3] = 1'b0;
    phase_cfg[4] = {8'd3, 8'd10};    phase_len[4] = 30;  phase_calm[4] = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].to_idle) begin
        while (seq_ph != PhIdle) begin
          f.mode      = dir_rows[i].fill_mode;
          f.data_byte = 8'($urandom_range(255));
          f.scl_in    = dir_rows[i].fill_scl;
          f.sda_in    = dir_rows[i].fill_sda;
          send_tick(f, 1'b0, '0);
        end
      end
    end
    settle();

    for (int k = 0; k < 5; k++) begin
      write_cfg(phase_cfg[k]);
      no_idle = phase_calm[k];
      repeat (phase_len[k]) send_tick(next_random_tick(), 1'b0, '0);
      // let the running command finish before the next register write
      while (seq_ph != PhIdle) send_tick(next_random_tick(), 1'b0, '0);
      settle();
      no_idle = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && drive_status_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/i2cm_pkg.sv
sv/i2cm_intf.sv
sv/i2cm_cfg_regs.sv
sv/i2cm_seq.sv
sv/i2c_master_byte_engine_top.sv
dv/tb.sv
